### hw/rtl/ptls_pkg.sv
// Package for the pan/tilt search generator: constants, opcodes and types.
// Used by the generator top level and the multiplier.
`default_nettype none
package ptls_pkg;
  localparam int unsigned ScanWrap = 655360;
  localparam int unsigned DtMaxUs = 50000;
  localparam int unsigned LocalUs = 1000000;
  localparam int unsigned TimeMax = 2097151;
  localparam int unsigned PanRateQ20 = 17499;
  localparam int unsigned DriftRateQ20 = 6562;
  localparam int GlobalPanAmp = 11520;
  localparam int GlobalTiltAmp = 6400;
  localparam int GlobalTiltCentre = -1280;

  // reciprocal multipliers: floor(x*17/10) = (x*M) >> 27,
  // floor(x/625) = (x*M) >> 32, floor(x/15625) = (x*M) >> 40
  localparam int unsigned Mul17Div10Q27 = 228170141;
  localparam int unsigned Recip625Q32 = 6871948;
  localparam int unsigned Recip15625Q40 = 70368745;

  localparam logic [2:0] RegPanMin = 3'd0;
  localparam logic [2:0] RegPanMax = 3'd1;
  localparam logic [2:0] RegTiltMin = 3'd2;
  localparam logic [2:0] RegTiltMax = 3'd3;
  localparam logic [2:0] RegSlew = 3'd4;
  localparam logic [2:0] RegSeen = 3'd5;
  localparam logic [2:0] RegLost = 3'd6;
  localparam logic [2:0] RegEdge = 3'd7;

  // shared multiplier request: unsigned a*b
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;
endpackage
`default_nettype wire

### hw/rtl/pan_tilt_lissajous_search.sv
// Pan/tilt Lissajous ball-search generator, top level.
// Depends on ptls_pkg and ptls_mul.
//
// Usage: one input word per servo tick on the in channel (valid/ready),
// one result word per input on the out channel (valid/ready).
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
// while the block is idle; the user must keep to this, the block does not enforce it.
// Each word runs through a sequencer that uses one shared registered
// multiplier for every product (phase steps, tilt phase, sine polynomial,
// cube, scaling, local amplitudes); a search word passes through every
// multiply state before its result is valid, a found word goes from the
// decision straight to the result. A new word is accepted only once the
// previous result has been taken, so words never overlap in the block.
// Reset clears all search state and restores register defaults; the first
// word after reset takes its measured angles as centre.
// While the receiver stalls the result is held and in_ready_o stays low.
`default_nettype none
module pan_tilt_lissajous_search
  import ptls_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int COUNT_WIDTH = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               detected_i,
  input  wire logic [19:0]        elapsed_us_i,
  input  wire logic signed [15:0] measured_pan_i,
  input  wire logic signed [15:0] measured_tilt_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    found_o,
  output logic signed [15:0]      pan_cmd_o,
  output logic signed [15:0]      tilt_cmd_o,
  output logic signed [1:0]       chassis_turn_o
);
  localparam int TabBits = $clog2(SINE_TABLE_DEPTH);
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  typedef enum logic [5:0] {
    S_IDLE, S_DECIDE, S_DP, S_DD, S_DPW, S_DDW, S_TP, S_TPW,
    S_SIN, S_Z2, S_Z2W, S_T1, S_T1W, S_T2, S_T2W, S_S, S_SW,
    S_CU1, S_CU1W, S_CU2, S_CU2W, S_AP, S_APW, S_AT, S_ATW,
    S_SC, S_SCW, S_FIN, S_UPD, S_OUT
  } state_e;

  state_e state_q;
  logic [15:0] pan_min_q, pan_max_q, tilt_min_q, tilt_max_q;
  logic [14:0] slew_q, edge_q;
  logic [7:0] seen_thr_q, lost_thr_q;
  logic started_q;
  logic signed [15:0] cpan_q, ctilt_q, lpan_q, ltilt_q;
  logic [19:0] scan_q;
  logic [15:0] drift_q;
  logic [COUNT_WIDTH-1:0] seen_q, miss_q;
  logic [20:0] since_seen_q, since_step_q;
  logic [15:0] dt_q;
  logic [15:0] tph_q;
  logic sel_q;                  // 0 pan sine, 1 tilt sine
  logic [15:0] z_q, z2_q, t_q, sp_q, st_q, amp_p_q, amp_t_q;
  logic negp_q, negt_q;
  logic [15:0] cube_q;
  logic signed [17:0] pan_t_q, tilt_t_q;
  logic local_q;
  logic out_valid_q, found_q;
  logic signed [15:0] pan_o_q, tilt_o_q;
  logic signed [1:0] turn_q;
  logic [20:0] ustmp_q;
  logic [1:0] quad_q;
  logic [15:0] mpan_q, mtilt_q;
  logic [19:0] el_q;
  logic det_q;

  mul_req_t req;
  logic [63:0] prod;
  ptls_mul u_mul (.clk_i(clk_i), .req_i(req), .prod_o(prod));

  // sine prep from phase
  logic [15:0] sph;
  logic [TabBits-1:0] sidx;
  logic [15:0] sa;
  logic [13:0] sr;
  logic [14:0] srr;
  always_comb begin
    sph = sel_q ? tph_q : scan_q[15:0];
    sidx = sph[15 -: TabBits];
    sa = 16'({sidx, {(16 - TabBits){1'b0}}});
    sr = sa[13:0];
    srr = sa[14] ? 15'(15'd16384 - 15'(sr)) : 15'(sr);
  end

  always_comb begin
    req = '0;
    case (state_q)
      S_DP:   req = '{a: 32'(dt_q), b: 32'(PanRateQ20)};
      S_DD:   req = '{a: 32'(dt_q), b: 32'(DriftRateQ20)};
      S_TP:   req = '{a: 32'(scan_q), b: 32'(Mul17Div10Q27)};
      S_Z2:   req = '{a: 32'(z_q), b: 32'(z_q)};
      S_T1:   req = '{a: 32'(z2_q), b: 32'd2611};
      S_T2:   req = '{a: 32'(z2_q), b: 32'(t_q)};
      S_S:    req = '{a: 32'(z_q), b: 32'(t_q)};
      S_CU1:  req = '{a: 32'(sp_q), b: 32'(sp_q)};
      S_CU2:  req = '{a: 32'(cube_q), b: 32'(sp_q)};
      S_AP:   req = '{a: 32'({ustmp_q, 2'b00}), b: 32'(Recip625Q32)};
      S_AT:   req = '{a: 32'({ustmp_q, 6'b000000}), b: 32'(Recip15625Q40)};
      S_SC:   req = '{a: 32'(amp_p_q), b: 32'(cube_q)};
      S_SCW:  req = '{a: 32'(amp_t_q), b: 32'(st_q)};
      default: req = '0;
    endcase
  end

  logic [20:0] sat_ss, sat_ss2;
  logic [21:0] tmp22a, tmp22b;
  logic [COUNT_WIDTH-1:0] seen_n, miss_n;
  logic [19:0] el_e;
  logic [63:0] prod_rnd;
  logic [20:0] scan_sum;
  logic [19:0] scan_n;
  logic [15:0] drift_n;
  logic [16:0] amp_p_sum, amp_t_sum;
  logic signed [17:0] pc, tc, pdiff, tdiff, pnew, tnew;
  logic signed [17:0] stp;
  logic [15:0] mag;
  always_comb begin
    el_e = started_q ? el_q : 20'd0;
    seen_n = det_q ? ((seen_q < CountMax) ? seen_q + 1'b1 : seen_q) : '0;
    miss_n = det_q ? '0 : ((miss_q < CountMax) ? miss_q + 1'b1 : miss_q);
    tmp22a = 22'(started_q ? since_seen_q : 21'd0) + 22'(el_e);
    sat_ss = det_q ? 21'd0 : ((tmp22a > 22'(TimeMax)) ? 21'(TimeMax) : tmp22a[20:0]);
    tmp22b = 22'(started_q ? since_step_q : 21'd0) + 22'(el_e);
    sat_ss2 = (tmp22b > 22'(TimeMax)) ? 21'(TimeMax) : tmp22b[20:0];
    // phase steps: (dt*rate + 2^19) >> 20
    prod_rnd = prod + 64'd524288;
    scan_sum = 21'(scan_q) + prod_rnd[40:20];
    scan_n = (scan_sum >= 21'(ScanWrap)) ? 20'(scan_sum - 21'(ScanWrap)) : scan_sum[19:0];
    drift_n = drift_q + prod_rnd[35:20];
    amp_p_sum = 17'd2560 + 17'(prod[47:32]);
    amp_t_sum = 17'd2048 + 17'(prod[55:40]);
    pc = pan_t_q;
    if (pc < 18'(signed'(pan_min_q))) pc = 18'(signed'(pan_min_q));
    if (pc > 18'(signed'(pan_max_q))) pc = 18'(signed'(pan_max_q));
    tc = tilt_t_q;
    if (tc < 18'(signed'(tilt_min_q))) tc = 18'(signed'(tilt_min_q));
    if (tc > 18'(signed'(tilt_max_q))) tc = 18'(signed'(tilt_max_q));
    stp = 18'(slew_q);
    pdiff = pc - 18'(lpan_q);
    if (pdiff > stp) pdiff = stp;
    if (pdiff < -stp) pdiff = -stp;
    tdiff = tc - 18'(ltilt_q);
    if (tdiff > stp) tdiff = stp;
    if (tdiff < -stp) tdiff = -stp;
    pnew = 18'(lpan_q) + pdiff;
    tnew = 18'(ltilt_q) + tdiff;
    mag = pnew[17] ? 16'(-pnew) : 16'(pnew);
  end

  logic [31:0] scaled;
  logic signed [17:0] samp;
  always_comb begin
    scaled = 32'((prod[47:0] + 48'd16384) >> 15);
    samp = 18'(scaled[16:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pan_min_q <= 16'hCE00; pan_max_q <= 16'd12800;
      tilt_min_q <= 16'hEC00; tilt_max_q <= 16'd21760;
      slew_q <= 15'd1536; seen_thr_q <= 8'd2; lost_thr_q <= 8'd5;
      edge_q <= 15'd10240;
      started_q <= 1'b0;
      cpan_q <= '0; ctilt_q <= '0; lpan_q <= '0; ltilt_q <= '0;
      scan_q <= '0; drift_q <= '0; seen_q <= '0; miss_q <= '0;
      since_seen_q <= '0; since_step_q <= '0;
      dt_q <= '0; tph_q <= '0; sel_q <= 1'b0;
      z_q <= '0; z2_q <= '0; t_q <= '0; sp_q <= '0; st_q <= '0;
      amp_p_q <= '0; amp_t_q <= '0; negp_q <= 1'b0; negt_q <= 1'b0;
      cube_q <= '0; pan_t_q <= '0; tilt_t_q <= '0; local_q <= 1'b0;
      out_valid_q <= 1'b0; found_q <= 1'b0;
      pan_o_q <= '0; tilt_o_q <= '0; turn_q <= '0;
      ustmp_q <= '0; quad_q <= '0;
      mpan_q <= '0; mtilt_q <= '0; el_q <= '0; det_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPanMin:  pan_min_q <= cfg_data_i;
          RegPanMax:  pan_max_q <= cfg_data_i;
          RegTiltMin: tilt_min_q <= cfg_data_i;
          RegTiltMax: tilt_max_q <= cfg_data_i;
          RegSlew:    slew_q <= cfg_data_i[14:0];
          RegSeen:    seen_thr_q <= cfg_data_i[7:0];
          RegLost:    lost_thr_q <= cfg_data_i[7:0];
          RegEdge:    edge_q <= cfg_data_i[14:0];
          default:    ;
        endcase
      end
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          det_q <= detected_i; el_q <= elapsed_us_i;
          mpan_q <= measured_pan_i; mtilt_q <= measured_tilt_i;
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          started_q <= 1'b1;
          seen_q <= seen_n; miss_q <= miss_n; since_seen_q <= sat_ss;
          if (32'(seen_n) >= 32'(seen_thr_q)) begin
            since_step_q <= sat_ss2;
            cpan_q <= mpan_q; lpan_q <= mpan_q;
            ctilt_q <= mtilt_q; ltilt_q <= mtilt_q;
            drift_q <= '0;
            found_q <= 1'b1; pan_o_q <= mpan_q; tilt_o_q <= mtilt_q;
            turn_q <= '0; out_valid_q <= 1'b1;
            state_q <= S_OUT;
          end else begin
            if (!started_q) begin
              cpan_q <= mpan_q; lpan_q <= mpan_q;
              ctilt_q <= mtilt_q; ltilt_q <= mtilt_q;
            end
            since_step_q <= '0;
            dt_q <= (sat_ss2 > 21'(DtMaxUs)) ? 16'(DtMaxUs) : sat_ss2[15:0];
            local_q <= sat_ss < 21'(LocalUs);
            ustmp_q <= sat_ss;
            state_q <= S_DP;
          end
        end
        // product of S_DP appears in S_DD, of S_DD in S_DPW
        S_DP:  state_q <= S_DD;
        S_DD: begin
          scan_q <= scan_n;
          state_q <= S_DPW;
        end
        S_DPW: begin
          drift_q <= drift_n;
          state_q <= S_DDW;
        end
        S_DDW: state_q <= S_TP;
        S_TP:  state_q <= S_TPW;
        S_TPW: begin
          tph_q <= prod[42:27] + drift_q;
          sel_q <= 1'b0; state_q <= S_SIN;
        end
        S_SIN: begin
          z_q <= 16'({srr, 1'b0}); quad_q <= sa[15:14]; state_q <= S_Z2;
        end
        S_Z2:  state_q <= S_Z2W;
        S_Z2W: begin z2_q <= 16'(prod >> 15); state_q <= S_T1; end
        S_T1:  state_q <= S_T1W;
        S_T1W: begin t_q <= 16'(64'd21167 - (prod >> 15)); state_q <= S_T2; end
        S_T2:  state_q <= S_T2W;
        S_T2W: begin t_q <= 16'(64'd51472 - (prod >> 15)); state_q <= S_S; end
        S_S:   state_q <= S_SW;
        S_SW: begin
          if (!sel_q) begin
            sp_q <= ((prod >> 15) > 64'd32767) ? 16'd32767 : 16'(prod >> 15);
            negp_q <= quad_q[1];
            sel_q <= 1'b1; state_q <= S_SIN;
          end else begin
            st_q <= ((prod >> 15) > 64'd32767) ? 16'd32767 : 16'(prod >> 15);
            negt_q <= quad_q[1];
            state_q <= S_CU1;
          end
        end
        S_CU1:  state_q <= S_CU1W;
        S_CU1W: begin cube_q <= 16'((prod + 64'd16384) >> 15); state_q <= S_CU2; end
        S_CU2:  state_q <= S_CU2W;
        S_CU2W: begin cube_q <= 16'((prod + 64'd16384) >> 15); state_q <= S_AP; end
        S_AP:   state_q <= S_APW;
        S_APW: begin
          amp_p_q <= (!local_q || amp_p_sum > 17'(GlobalPanAmp))
                     ? 16'(GlobalPanAmp) : amp_p_sum[15:0];
          state_q <= S_AT;
        end
        S_AT:   state_q <= S_ATW;
        S_ATW: begin
          amp_t_q <= (!local_q || amp_t_sum > 17'(GlobalTiltAmp))
                     ? 16'(GlobalTiltAmp) : amp_t_sum[15:0];
          state_q <= S_SC;
        end
        S_SC:   state_q <= S_SCW;
        S_SCW: begin
          pan_t_q <= (local_q ? 18'(cpan_q) : 18'sd0) + (negp_q ? -samp : samp);
          state_q <= S_FIN;
        end
        S_FIN: begin
          tilt_t_q <= (local_q ? 18'(ctilt_q) : 18'(GlobalTiltCentre))
                      + (negt_q ? -samp : samp);
          found_q <= 1'b0;
          state_q <= S_UPD;
        end
        S_UPD: begin
          lpan_q <= 16'(pnew); ltilt_q <= 16'(tnew);
          pan_o_q <= 16'(pnew); tilt_o_q <= 16'(tnew);
          turn_q <= (32'(mag) > 32'(edge_q) && 32'(miss_q) >= 32'(lost_thr_q))
                    ? (pnew > 0 ? 2'sd1 : -2'sd1) : 2'sd0;
          out_valid_q <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0; state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign found_o = found_q;
  assign pan_cmd_o = pan_o_q;
  assign tilt_cmd_o = tilt_o_q;
  assign chassis_turn_o = turn_q;
endmodule
`default_nettype wire

### hw/rtl/ptls_mul.sv
// Shared registered 32x32 unsigned multiplier for the search generator.
// Depends on ptls_pkg.
`default_nettype none
module ptls_mul
  import ptls_pkg::*;
(
  input  wire logic     clk_i,
  input  wire mul_req_t req_i,
  output logic [63:0]   prod_o
);
  logic [63:0] prod_q;
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(req_i.a) * 64'(req_i.b);
  end
  assign prod_o = prod_q;
endmodule
`default_nettype wire

### hw/rtl/ptls_checker.sv
// Port-level checks for the pan/tilt search generator.
// Bound to pan_tilt_lissajous_search.
`default_nettype none
module ptls_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic found_o,
  input wire logic signed [1:0] chassis_turn_o
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while result pending");
  a_turn_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chassis_turn_o != 2'b10) else $error("bad turn code");
  a_found_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> chassis_turn_o == 2'b00) else $error("turn while found");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready after accept");
endmodule

bind pan_tilt_lissajous_search ptls_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .found_o(found_o),
  .chassis_turn_o(chassis_turn_o)
);
`default_nettype wire

### tb/pan_tilt_lissajous_search_tb.sv
// Testbench for pan_tilt_lissajous_search: drives servo-tick words, predicts
// each search/found result in-line and compares it field by field.
// Depends on ptls_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module pan_tilt_lissajous_search_tb
  import ptls_pkg::*;
;

  localparam int SineDepth = 256;
  localparam int CountMax = 255;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic               found;
    logic signed [15:0] pan;
    logic signed [15:0] tilt;
    logic signed [1:0]  turn;
  } cmd_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic detected_i = 1'b0;
  logic [19:0] elapsed_us_i = '0;
  logic signed [15:0] measured_pan_i = '0;
  logic signed [15:0] measured_tilt_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic found_o;
  logic signed [15:0] pan_cmd_o;
  logic signed [15:0] tilt_cmd_o;
  logic signed [1:0] chassis_turn_o;

  pan_tilt_lissajous_search u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .detected_i, .elapsed_us_i,
    .measured_pan_i, .measured_tilt_i,
    .out_valid_o, .out_ready_i, .found_o, .pan_cmd_o, .tilt_cmd_o,
    .chassis_turn_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // predictor state
  int lim_pan_lo, lim_pan_hi, lim_tilt_lo, lim_tilt_hi;
  int slew_lim, seen_thr, lost_thr, edge_lim;
  bit started;
  int ctr_pan, ctr_tilt, prev_pan, prev_tilt;
  longint unsigned pan_phase, drift_ph;
  int unsigned hit_run, miss_cnt;
  longint unsigned seen_age_us, unstepped_us;

  cmd_word_t expected_cmds[$];
  int errors = 0;
  int n_words = 0;
  int n_found = 0;
  int n_turn = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  function automatic longint unsigned sat_time(longint unsigned a, longint unsigned b);
    return (a + b > TimeMax) ? TimeMax : a + b;
  endfunction

  function automatic int sine_lut(longint unsigned ph);
    longint unsigned idx, a, r, z, z2, t, s;
    int unsigned quad;
    idx = ((ph & 64'hFFFF) * SineDepth) >> 16;
    a = (idx * 65536) / SineDepth;
    quad = (a >> 14) & 3;
    r = a & 64'h3FFF;
    if (quad[0]) r = 16384 - r;
    z = r << 1;
    z2 = (z * z) >> 15;
    t = 21167 - ((z2 * 2611) >> 15);
    t = 51472 - ((z2 * t) >> 15);
    s = (z * t) >> 15;
    if (s > 32767) s = 32767;
    return (quad >= 2) ? -int'(s) : int'(s);
  endfunction

  function automatic int amp_mul(int amp, int s);
    longint unsigned m;
    int p;
    m = (s < 0) ? -s : s;
    p = int'((longint'(amp) * m + 16384) >> 15);
    return (s < 0) ? -p : p;
  endfunction

  function automatic int cubed(int s);
    longint unsigned m, m2;
    int c;
    m = (s < 0) ? -s : s;
    m2 = (m * m + 16384) >> 15;
    c = int'((m2 * m + 16384) >> 15);
    return (s < 0) ? -c : c;
  endfunction

  function automatic int limit_slew(int prev, int target);
    int d;
    d = target - prev;
    if (d > slew_lim) d = slew_lim;
    if (d < -slew_lim) d = -slew_lim;
    return prev + d;
  endfunction

  function automatic cmd_word_t search_step(bit det, int unsigned el, int mp, int mt);
    cmd_word_t w;
    longint unsigned dt, dpan, ddr, tph, us;
    int amp_p, amp_t, cp, ct, pan, tilt, mag;
    if (!started) begin
      ctr_pan = mp; prev_pan = mp; ctr_tilt = mt; prev_tilt = mt;
      seen_age_us = 0; unstepped_us = 0; el = 0; started = 1'b1;
    end
    if (det) begin
      if (hit_run < CountMax) hit_run++;
      miss_cnt = 0;
      seen_age_us = 0;
    end else begin
      if (miss_cnt < CountMax) miss_cnt++;
      hit_run = 0;
      seen_age_us = sat_time(seen_age_us, el);
    end
    unstepped_us = sat_time(unstepped_us, el);
    if (hit_run >= seen_thr) begin
      ctr_pan = mp; prev_pan = mp; ctr_tilt = mt; prev_tilt = mt;
      drift_ph = 0;
      w.found = 1'b1; w.pan = mp[15:0]; w.tilt = mt[15:0]; w.turn = 2'sd0;
      return w;
    end
    dt = (unstepped_us > DtMaxUs) ? DtMaxUs : unstepped_us;
    unstepped_us = 0;
    if (seen_age_us < LocalUs) begin
      us = seen_age_us;
      amp_p = 2560 + int'((us * 6400) / 1000000);
      amp_t = 2048 + int'((us * 4096) / 1000000);
      if (amp_p > GlobalPanAmp) amp_p = GlobalPanAmp;
      if (amp_t > GlobalTiltAmp) amp_t = GlobalTiltAmp;
      cp = ctr_pan; ct = ctr_tilt;
    end else begin
      amp_p = GlobalPanAmp; amp_t = GlobalTiltAmp;
      cp = 0; ct = GlobalTiltCentre;
    end
    dpan = (dt * PanRateQ20 + (1 << 19)) >> 20;
    ddr = (dt * DriftRateQ20 + (1 << 19)) >> 20;
    pan_phase = (pan_phase + dpan) % ScanWrap;
    drift_ph = (drift_ph + ddr) & 64'hFFFF;
    tph = ((pan_phase * 17) / 10 + drift_ph) & 64'hFFFF;
    pan = cp + amp_mul(amp_p, cubed(sine_lut(pan_phase & 64'hFFFF)));
    tilt = ct + amp_mul(amp_t, sine_lut(tph));
    if (pan < lim_pan_lo) pan = lim_pan_lo;
    if (pan > lim_pan_hi) pan = lim_pan_hi;
    if (tilt < lim_tilt_lo) tilt = lim_tilt_lo;
    if (tilt > lim_tilt_hi) tilt = lim_tilt_hi;
    prev_pan = limit_slew(prev_pan, pan);
    prev_tilt = limit_slew(prev_tilt, tilt);
    mag = (prev_pan < 0) ? -prev_pan : prev_pan;
    w.turn = 2'sd0;
    if (mag > edge_lim && miss_cnt >= lost_thr) w.turn = (prev_pan > 0) ? 2'sd1 : -2'sd1;
    w.found = 1'b0; w.pan = prev_pan[15:0]; w.tilt = prev_tilt[15:0];
    return w;
  endfunction

  task automatic write_reg(logic [2:0] idx, int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val[15:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegPanMin:  lim_pan_lo = int'($signed(val[15:0]));
      RegPanMax:  lim_pan_hi = int'($signed(val[15:0]));
      RegTiltMin: lim_tilt_lo = int'($signed(val[15:0]));
      RegTiltMax: lim_tilt_hi = int'($signed(val[15:0]));
      RegSlew:    slew_lim = val & 16'h7FFF;
      RegSeen:    seen_thr = val & 8'hFF;
      RegLost:    lost_thr = val & 8'hFF;
      RegEdge:    edge_lim = val & 16'h7FFF;
      default:    ;
    endcase
  endtask

  task automatic set_limits(int plo, int phi, int tlo, int thi, int slw, int sn, int ls, int edg);
    write_reg(RegPanMin, plo); write_reg(RegPanMax, phi);
    write_reg(RegTiltMin, tlo); write_reg(RegTiltMax, thi);
    write_reg(RegSlew, slw); write_reg(RegSeen, sn);
    write_reg(RegLost, ls); write_reg(RegEdge, edg);
  endtask

  // gaps: mostly none or short, now and then long
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_tick(bit det, int unsigned el, int mp, int mt);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    detected_i <= det;
    elapsed_us_i <= el[19:0];
    measured_pan_i <= mp[15:0];
    measured_tilt_i <= mt[15:0];
    do @(posedge clk_i); while (!in_ready_o);
    expected_cmds.push_back(search_step(det, el & 32'hFFFFF, mp, mt));
    n_words++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic int rand_s16();
    return int'($signed(16'($urandom())));
  endfunction

  task automatic test_directed();
    send_tick(1'b0, 20'hFFFFF, -32768, 32767);
    send_tick(1'b0, 20'hFFFFF, 32767, -32768);
    send_tick(1'b0, 0, 0, 0);
    send_tick(1'b0, 50000, 0, 0);
    send_tick(1'b1, 33000, 1000, -500);
    send_tick(1'b1, 33000, 1200, -400);
    send_tick(1'b1, 33000, -1200, 400);
    repeat (6) send_tick(1'b0, 33000, 0, 0);
    repeat (4) send_tick(1'b0, 20'hFFFFF, 0, 0);
    send_tick(1'b0, 1, 0, 0);
    send_tick(1'b1, 50001, 0, 0);
    send_tick(1'b0, 49999, 0, 0);
    wait_drain();
  endtask

  task automatic test_thresholds();
    // zero seen threshold: every tick found; huge lost threshold never met
    set_limits(-32768, 32767, -32768, 32767, 32767, 0, 255, 0);
    repeat (8) send_tick($urandom_range(0, 1), $urandom_range(0, 100000), rand_s16(), rand_s16());
    wait_drain();
    // inverted limits, no slew, max threshold on seen
    set_limits(5000, -5000, 3000, -3000, 0, 255, 1, 32767);
    repeat (8) send_tick($urandom_range(0, 1), $urandom_range(0, 100000), rand_s16(), rand_s16());
    wait_drain();
    set_limits(32767, -32768, 32767, -32768, 32767, 1, 0, 100);
    repeat (8) send_tick($urandom_range(0, 1), $urandom_range(0, 100000), rand_s16(), rand_s16());
    wait_drain();
  endtask

  task automatic test_random(int count);
    int k;
    int unsigned el;
    bit det;
    for (k = 0; k < count; k++) begin
      if (k % 250 == 0) begin
        wait_drain();
        set_limits($urandom_range(0, 3) == 0 ? rand_s16() : -12800 - $urandom_range(0, 8000),
                   $urandom_range(0, 3) == 0 ? rand_s16() : 12800 + $urandom_range(0, 8000),
                   $urandom_range(0, 3) == 0 ? rand_s16() : -5120,
                   $urandom_range(0, 3) == 0 ? rand_s16() : 21760,
                   $urandom_range(0, 4) == 0 ? $urandom_range(0, 32767) : $urandom_range(200, 3000),
                   $urandom_range(0, 5) == 0 ? $urandom_range(0, 255) : $urandom_range(1, 4),
                   $urandom_range(0, 5) == 0 ? $urandom_range(0, 255) : $urandom_range(1, 8),
                   $urandom_range(0, 4) == 0 ? $urandom_range(0, 32767) : $urandom_range(2000, 11000));
      end
      // sparse random detections, long miss runs, and occasional noise
      det = ($urandom_range(0, 9) < 2);
      case ($urandom_range(0, 9))
        0: el = $urandom();
        1: el = $urandom_range(0, 100);
        default: el = $urandom_range(20000, 60000);
      endcase
      send_tick(det, el, rand_s16() / ($urandom_range(0, 1) ? 1 : 8),
                rand_s16() / ($urandom_range(0, 1) ? 1 : 8));
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (6) send_tick(1'b0, 40000, 0, 0);
        in_valid_i <= 1'b0;
      end
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    wait_drain();
  endtask

  // receiver: random stalls, checks each accepted word
  always @(posedge clk_i) begin
    cmd_word_t e;
    if (out_valid_o && out_ready_i) begin
      if (expected_cmds.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        e = expected_cmds.pop_front();
        if (found_o !== e.found) begin
          $error("found: expected %0d got %0d", e.found, found_o); errors++;
        end
        if (pan_cmd_o !== e.pan) begin
          $error("pan_cmd: expected %0d got %0d", e.pan, pan_cmd_o); errors++;
        end
        if (tilt_cmd_o !== e.tilt) begin
          $error("tilt_cmd: expected %0d got %0d", e.tilt, tilt_cmd_o); errors++;
        end
        if (chassis_turn_o !== e.turn) begin
          $error("chassis_turn: expected %0d got %0d", e.turn, chassis_turn_o); errors++;
        end
        if (e.found) n_found++;
        if (e.turn != 0) n_turn++;
      end
    end
    out_ready_i <= !hold_off && ($urandom_range(0, 9) < 7 || $urandom_range(0, 3) == 0);
  end

  // watchdog on cycles without a handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || hold_off || !rst_ni
        || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    lim_pan_lo = -12800; lim_pan_hi = 12800; lim_tilt_lo = -5120; lim_tilt_hi = 21760;
    slew_lim = 1536; seen_thr = 2; lost_thr = 5; edge_lim = 10240;
    started = 1'b0; ctr_pan = 0; ctr_tilt = 0; prev_pan = 0; prev_tilt = 0;
    pan_phase = 0; drift_ph = 0; hit_run = 0; miss_cnt = 0;
    seen_age_us = 0; unstepped_us = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_thresholds();
    test_backpressure();
    test_random(1050);
    $display("Covered %0d ticks: %0d found, %0d with chassis assist.", n_words, n_found,
             n_turn);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire
